// ----- hdl/lowest_free_slot_tag_table_macros.svh -----
// Assertion macros for the lowest free slot tag table.
// Depends on nothing; expects aclk and aresetn in the including module.
`ifndef LOWEST_FREE_SLOT_TAG_TABLE_MACROS_SVH
`define LOWEST_FREE_SLOT_TAG_TABLE_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define LFST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also applies during reset.
`define LFST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hdl/lfst_pkg.sv -----
// Shared types and constants for the lowest free slot tag table.
// No dependencies.
package lfst_pkg;

    localparam int DEF_SLOTS = 64;
    localparam int SW    = 7;
    localparam int TAGW  = 64;
    localparam int ATTRW = 8;
    localparam int OPW   = 3;
    localparam int STW   = 2;

    localparam logic [OPW-1:0] OP_PARK       = 3'd0;
    localparam logic [OPW-1:0] OP_LEAVE      = 3'd1;
    localparam logic [OPW-1:0] OP_FIND       = 3'd2;
    localparam logic [OPW-1:0] OP_LIST_SLOTS = 3'd3;
    localparam logic [OPW-1:0] OP_LIST_TAGS  = 3'd4;

    localparam logic [STW-1:0] ST_OK        = 2'd0;
    localparam logic [STW-1:0] ST_FULL      = 2'd1;
    localparam logic [STW-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STW-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        PK_PARK_OK,
        PK_FULL,
        PK_EMPTY,
        PK_LEAVE,
        PK_PEND,
        PK_NOT_FOUND
    } push_kind_t;

    typedef struct packed {
        logic       load;
        logic       park_write;
        logic       leave_do;
        logic       rd_leave;
        logic       rd_scan;
        logic       ptr_inc;
        logic       pend_take;
        logic       push;
        logic       push_last;
        push_kind_t push_kind;
    } cmd_t;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic           park_end;
        logic           park_free;
        logic           leave_ok;
        logic           scan_end;
        logic           match;
        logic           pend_valid;
        logic           out_free;
    } sts_t;

endpackage

// ----- hdl/lowest_free_slot_tag_table.sv -----
// Top level of the lowest free slot tag table.
// Depends on lfst_pkg, lfst_ctrl and lfst_dp.
//
// A table of SLOTS slots (numbered from 1) holding a 64-bit tag and an 8-bit
// attribute each. Park takes the lowest free slot at or below slot_count;
// leave frees a slot and returns its contents; find returns the latest
// parked slot holding a tag; the two list operations walk the occupied slots
// in parking order and return every slot or tag with the given attribute,
// with m_last on the final one (an empty list gives one not-found item).
// One item is handled at a time; s_ready is high only between operations.
// Timing: park scans one slot per cycle; leave reads the slot, then frees it
// and returns it; find and the lists read the tag memory once per occupied
// slot through its single registered read port, in a read state and then a
// check state per slot, and wait while the output stalls. The result
// register lets the next item be taken while a result still waits.
// After reset the table is empty at once; no clearing pass is needed.
module lowest_free_slot_tag_table
    import lfst_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration: slot_count
    input  logic             cfg_wr_en,
    input  logic [SW-1:0]    cfg_wr_data,
    // input items
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OPW-1:0]   s_op,
    input  logic [TAGW-1:0]  s_tag,
    input  logic [ATTRW-1:0] s_attribute,
    input  logic [SW-1:0]    s_slot_index,
    // result items
    output logic             m_valid,
    input  logic             m_ready,
    output logic [STW-1:0]   m_status,
    output logic [SW-1:0]    m_result_slot,
    output logic [TAGW-1:0]  m_result_tag,
    output logic [ATTRW-1:0] m_result_attribute,
    output logic             m_last
);

    cmd_t cmd;
    sts_t sts;

    // sequence each operation
    lfst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold the table and format each result item
    lfst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_op               (s_op),
        .s_tag              (s_tag),
        .s_attribute        (s_attribute),
        .s_slot_index       (s_slot_index),
        .cmd                (cmd),
        .sts                (sts),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_result_slot      (m_result_slot),
        .m_result_tag       (m_result_tag),
        .m_result_attribute (m_result_attribute),
        .m_last             (m_last)
    );

endmodule

// ----- hdl/lfst_ctrl.sv -----
// Controller state machine for the lowest free slot tag table.
// Depends on lfst_pkg; drives the datapath by cmd_t, reads sts_t.
module lfst_ctrl
    import lfst_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic [OPW-1:0] s_op,
    output logic           s_ready,
    input  sts_t           sts,
    output cmd_t           cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_PARK     = 6'b000010,
        S_LEAVE    = 6'b000100,
        S_LEAVE_WB = 6'b001000,
        S_SCAN_RD  = 6'b010000,
        S_SCAN_CHK = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.push_kind = PK_NOT_FOUND;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_op)
                        OP_PARK:  state_next = S_PARK;
                        OP_LEAVE: state_next = S_LEAVE;
                        OP_FIND, OP_LIST_SLOTS, OP_LIST_TAGS: state_next = S_SCAN_RD;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_PARK: begin
                if (sts.park_end) begin
                    if (sts.out_free) begin
                        cmd.push = 1'b1; cmd.push_last = 1'b1; cmd.push_kind = PK_FULL;
                        state_next = S_IDLE;
                    end
                end else if (sts.park_free) begin
                    if (sts.out_free) begin
                        cmd.park_write = 1'b1;
                        cmd.push = 1'b1; cmd.push_last = 1'b1; cmd.push_kind = PK_PARK_OK;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_LEAVE: begin
                if (!sts.leave_ok) begin
                    if (sts.out_free) begin
                        cmd.push = 1'b1; cmd.push_last = 1'b1; cmd.push_kind = PK_EMPTY;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.rd_leave = 1'b1;
                    state_next   = S_LEAVE_WB;
                end
            end
            S_LEAVE_WB: begin
                if (sts.out_free) begin
                    cmd.leave_do = 1'b1;
                    cmd.push = 1'b1; cmd.push_last = 1'b1; cmd.push_kind = PK_LEAVE;
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                if (sts.scan_end) begin
                    if (sts.out_free) begin
                        cmd.push = 1'b1; cmd.push_last = 1'b1;
                        cmd.push_kind = sts.pend_valid ? PK_PEND : PK_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!sts.match) begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end else if ((sts.op != OP_FIND) && sts.pend_valid) begin
                    // flush the previous match before holding the new one
                    if (sts.out_free) begin
                        cmd.push = 1'b1; cmd.push_kind = PK_PEND;
                        cmd.pend_take = 1'b1;
                        cmd.ptr_inc   = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                end else begin
                    cmd.pend_take = 1'b1;
                    cmd.ptr_inc   = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- hdl/lfst_dp.sv -----
// Datapath for the lowest free slot tag table: slot state, park order,
// tag memory and result register. Depends on lfst_pkg and the macro header.
`include "lowest_free_slot_tag_table_macros.svh"
module lfst_dp
    import lfst_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [SW-1:0]    cfg_wr_data,
    input  logic [OPW-1:0]   s_op,
    input  logic [TAGW-1:0]  s_tag,
    input  logic [ATTRW-1:0] s_attribute,
    input  logic [SW-1:0]    s_slot_index,
    input  cmd_t             cmd,
    output sts_t             sts,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [STW-1:0]   m_status,
    output logic [SW-1:0]    m_result_slot,
    output logic [TAGW-1:0]  m_result_tag,
    output logic [ATTRW-1:0] m_result_attribute,
    output logic             m_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0]       occ_reg;
    logic [SW-1:0]          count_reg;
    logic [SW-1:0]          slot_count_reg;
    logic [TAGW+ATTRW-1:0]  mem [SLOTS];
    logic [TAGW+ATTRW-1:0]  rd_reg;
    logic [SW-1:0]          rd_slot_reg;

    // park order as a doubly linked list of occupied slots, oldest at the head
    logic [IW-1:0]          nxt_mem [SLOTS];
    logic [IW-1:0]          prv_mem [SLOTS];
    logic [IW-1:0]          nxt_rd_reg;
    logic [IW-1:0]          prv_rd_reg;
    logic [IW-1:0]          head_reg;
    logic [IW-1:0]          tail_reg;
    logic [IW-1:0]          cur_reg;

    logic [OPW-1:0]   op_reg;
    logic [TAGW-1:0]  tag_reg;
    logic [ATTRW-1:0] attr_reg;
    logic [SW-1:0]    idx_reg;
    logic [SW-1:0]    ptr_reg;

    logic             pend_valid_reg;
    logic [SW-1:0]    pend_slot_reg;
    logic [TAGW-1:0]  pend_tag_reg;

    logic             m_valid_reg;
    logic [STW-1:0]   status_reg;
    logic [SW-1:0]    slot_reg;
    logic [TAGW-1:0]  otag_reg;
    logic [ATTRW-1:0] oattr_reg;
    logic             last_reg;

    logic [SW-1:0]    limit;
    logic [SW-1:0]    idx_m1;
    logic [IW-1:0]    ptr_i;
    logic [IW-1:0]    leave_i;
    logic [IW-1:0]    rd_addr;
    logic [TAGW-1:0]  rd_tag;
    logic [ATTRW-1:0] rd_attr;
    logic             out_free;

    assign limit   = (slot_count_reg > SW'(SLOTS)) ? SW'(SLOTS) : slot_count_reg;
    assign idx_m1  = idx_reg - SW'(1);
    assign ptr_i   = ptr_reg[IW-1:0];
    assign leave_i = idx_m1[IW-1:0];
    assign rd_addr = cmd.rd_leave ? leave_i : cur_reg;
    assign rd_tag  = rd_reg[TAGW+ATTRW-1:ATTRW];
    assign rd_attr = rd_reg[ATTRW-1:0];
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        sts            = '0;
        sts.op         = op_reg;
        sts.park_end   = (ptr_reg >= limit);
        sts.park_free  = !occ_reg[ptr_i];
        sts.leave_ok   = (idx_reg != '0) && (idx_reg <= SW'(SLOTS)) && occ_reg[leave_i];
        sts.scan_end   = (ptr_reg >= count_reg);
        sts.match      = (op_reg == OP_FIND) ? (rd_tag == tag_reg) : (rd_attr == attr_reg);
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= SW'(DEF_SLOTS);
            occ_reg        <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                slot_count_reg <= cfg_wr_data;
            end
            if (cmd.park_write) begin
                occ_reg[ptr_i] <= 1'b1;
                count_reg      <= count_reg + SW'(1);
                tail_reg       <= ptr_i;
                if (count_reg == '0) begin
                    head_reg <= ptr_i;
                end
            end
            if (cmd.leave_do) begin
                occ_reg[leave_i] <= 1'b0;
                count_reg        <= count_reg - SW'(1);
                if (leave_i == head_reg) begin
                    head_reg <= nxt_rd_reg;
                end
                if (leave_i == tail_reg) begin
                    tail_reg <= prv_rd_reg;
                end
            end
            if (cmd.load) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.pend_take) begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // park order links: append on park, unlink on leave
    always_ff @(posedge aclk) begin
        if (cmd.park_write) begin
            prv_mem[ptr_i] <= tail_reg;
            if (count_reg != '0) begin
                nxt_mem[tail_reg] <= ptr_i;
            end
        end
        if (cmd.leave_do) begin
            if (leave_i != head_reg) begin
                nxt_mem[prv_rd_reg] <= nxt_rd_reg;
            end
            if (leave_i != tail_reg) begin
                prv_mem[nxt_rd_reg] <= prv_rd_reg;
            end
        end
        if (cmd.rd_leave || cmd.rd_scan) begin
            nxt_rd_reg <= nxt_mem[rd_addr];
            prv_rd_reg <= prv_mem[rd_addr];
        end
    end

    // tag and attribute memory
    always_ff @(posedge aclk) begin
        if (cmd.park_write) begin
            mem[ptr_i] <= {tag_reg, attr_reg};
        end
        if (cmd.rd_leave || cmd.rd_scan) begin
            rd_reg      <= mem[rd_addr];
            rd_slot_reg <= SW'(rd_addr) + SW'(1);
        end
    end

    // captured item, scan pointer and cursor, pending match, result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_op;
            tag_reg  <= s_tag;
            attr_reg <= s_attribute;
            idx_reg  <= s_slot_index;
            ptr_reg  <= '0;
            cur_reg  <= head_reg;
        end else if (cmd.ptr_inc) begin
            ptr_reg  <= ptr_reg + SW'(1);
            cur_reg  <= nxt_rd_reg;
        end
        if (cmd.pend_take) begin
            pend_slot_reg <= rd_slot_reg;
            pend_tag_reg  <= rd_tag;
        end
        if (cmd.push) begin
            status_reg <= ST_OK;
            slot_reg   <= '0;
            otag_reg   <= '0;
            oattr_reg  <= '0;
            last_reg   <= cmd.push_last;
            case (cmd.push_kind)
                PK_PARK_OK: slot_reg <= ptr_reg + SW'(1);
                PK_FULL:    status_reg <= ST_FULL;
                PK_EMPTY:   status_reg <= ST_EMPTY;
                PK_LEAVE: begin
                    slot_reg  <= idx_reg;
                    otag_reg  <= rd_tag;
                    oattr_reg <= rd_attr;
                end
                PK_PEND: begin
                    if (op_reg == OP_LIST_TAGS) begin
                        otag_reg <= pend_tag_reg;
                    end else begin
                        slot_reg <= pend_slot_reg;
                    end
                end
                default: status_reg <= ST_NOT_FOUND;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_result_slot      = slot_reg;
    assign m_result_tag       = otag_reg;
    assign m_result_attribute = oattr_reg;
    assign m_last             = last_reg;

    `LFST_ASSERT(a_push_room, cmd.push |-> out_free, "result pushed over a held item")
    `LFST_ASSERT(a_count_match, count_reg == SW'($countones(occ_reg)), "occupied count drift")
    `LFST_ASSERT(a_park_free, cmd.park_write |-> !occ_reg[ptr_i], "park over occupied slot")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the lowest free slot tag table.
// Depends on lfst_pkg and lowest_free_slot_tag_table; holds its own slot-table predictor.
// Directed table first, then randomised phases under several slot_count settings.
module tb_top;
    import lfst_pkg::*;

    localparam int NSLOT = 64;
    localparam logic [OPW-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OPW-1:0] OP_SPARE_7 = 3'd7;
    // longest gap an item can need with no result to show for it
    localparam int QUIET_CYCLES = 2 * NSLOT + 80;

    typedef struct {
        logic [STW-1:0]   status;
        logic [SW-1:0]    slot;
        logic [TAGW-1:0]  tag;
        logic [ATTRW-1:0] attr;
        logic             last;
    } outcome_t;

    typedef struct {
        logic [OPW-1:0]   op;
        logic [TAGW-1:0]  tag;
        logic [ATTRW-1:0] attr;
        logic [SW-1:0]    idx;
        bit               typed;
        outcome_t         want;
    } row_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [SW-1:0]    cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic [OPW-1:0]   s_op;
    logic [TAGW-1:0]  s_tag;
    logic [ATTRW-1:0] s_attribute;
    logic [SW-1:0]    s_slot_index;
    logic             m_valid;
    logic             m_ready;
    logic [STW-1:0]   m_status;
    logic [SW-1:0]    m_result_slot;
    logic [TAGW-1:0]  m_result_tag;
    logic [ATTRW-1:0] m_result_attribute;
    logic             m_last;

    lowest_free_slot_tag_table dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_tag              (s_tag),
        .s_attribute        (s_attribute),
        .s_slot_index       (s_slot_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_result_slot      (m_result_slot),
        .m_result_tag       (m_result_tag),
        .m_result_attribute (m_result_attribute),
        .m_last             (m_last)
    );

    // Clock: 12 units per period.
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Slot table shadow: occupancy, contents, parking order and limit
    // ---------------------------------------------------------------
    bit               shadow_occ  [NSLOT];
    logic [TAGW-1:0]  shadow_tag  [NSLOT];
    logic [ATTRW-1:0] shadow_attr [NSLOT];
    int               shadow_rank [NSLOT];
    int               shadow_count;
    int               slot_limit;

    outcome_t step_results[$];     // results of the item just accepted
    outcome_t awaited_results[$];  // results still owed by the block

    int  errors;
    int  results_seen;
    bit  sender_idles;
    row_t dir_rows[$];
    logic [TAGW-1:0] tag_pool [4];

    function automatic outcome_t mk(logic [STW-1:0] st, logic [SW-1:0] sl,
                                    logic [TAGW-1:0] tg, logic [ATTRW-1:0] at,
                                    logic lst);
        outcome_t o;
        o.status = st;
        o.slot   = sl;
        o.tag    = tg;
        o.attr   = at;
        o.last   = lst;
        return o;
    endfunction

    // Append one predicted result for the current item.
    function automatic void add_step(outcome_t o);
        step_results = {step_results, o};
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(row_t r);
        dir_rows = {dir_rows, r};
    endfunction

    // Advance the shadow table by one item and leave its results in step_results.
    function automatic void table_step(row_t it);
        int cap;
        int best;
        int best_rank;
        int gone;
        int n;
        step_results.delete();
        cap = (slot_limit > NSLOT) ? NSLOT : slot_limit;
        case (it.op)
            OP_PARK: begin
                for (int s = 0; s < cap; s++) begin
                    if (!shadow_occ[s]) begin
                        shadow_occ[s]  = 1'b1;
                        shadow_tag[s]  = it.tag;
                        shadow_attr[s] = it.attr;
                        shadow_rank[s] = shadow_count;
                        shadow_count++;
                        add_step(mk(ST_OK, SW'(s + 1), '0, '0, 1'b1));
                        return;
                    end
                end
                add_step(mk(ST_FULL, '0, '0, '0, 1'b1));
            end
            OP_LEAVE: begin
                if (it.idx >= 1 && it.idx <= NSLOT && shadow_occ[it.idx - 1]) begin
                    gone = shadow_rank[it.idx - 1];
                    shadow_occ[it.idx - 1] = 1'b0;
                    for (int s = 0; s < NSLOT; s++)
                        if (shadow_occ[s] && shadow_rank[s] > gone)
                            shadow_rank[s]--;
                    shadow_count--;
                    add_step(mk(ST_OK, it.idx, shadow_tag[it.idx - 1],
                                shadow_attr[it.idx - 1], 1'b1));
                end else begin
                    add_step(mk(ST_EMPTY, '0, '0, '0, 1'b1));
                end
            end
            OP_FIND: begin
                best = 0;
                best_rank = 0;
                for (int s = 0; s < NSLOT; s++) begin
                    if (shadow_occ[s] && shadow_tag[s] == it.tag &&
                        (best == 0 || shadow_rank[s] > best_rank)) begin
                        best = s + 1;
                        best_rank = shadow_rank[s];
                    end
                end
                if (best != 0)
                    add_step(mk(ST_OK, SW'(best), '0, '0, 1'b1));
                else
                    add_step(mk(ST_NOT_FOUND, '0, '0, '0, 1'b1));
            end
            OP_LIST_SLOTS, OP_LIST_TAGS: begin
                n = 0;
                for (int r = 0; r < shadow_count; r++) begin
                    for (int s = 0; s < NSLOT; s++) begin
                        if (shadow_occ[s] && shadow_rank[s] == r &&
                            shadow_attr[s] == it.attr) begin
                            if (it.op == OP_LIST_SLOTS)
                                add_step(mk(ST_OK, SW'(s + 1), '0, '0, 1'b0));
                            else
                                add_step(mk(ST_OK, '0, shadow_tag[s], '0, 1'b0));
                            n++;
                        end
                    end
                end
                if (n == 0)
                    add_step(mk(ST_NOT_FOUND, '0, '0, '0, 1'b1));
                else
                    step_results[n - 1].last = 1'b1;
            end
            default: ;  // spare op codes: drop, nothing changes
        endcase
    endfunction

    function automatic row_t item(logic [OPW-1:0] op, logic [TAGW-1:0] tg,
                                  logic [ATTRW-1:0] at, logic [SW-1:0] ix);
        row_t r;
        r.op    = op;
        r.tag   = tg;
        r.attr  = at;
        r.idx   = ix;
        r.typed = 1'b0;
        r.want  = mk('0, '0, '0, '0, 1'b0);
        return r;
    endfunction

    function automatic row_t typed_item(row_t r, outcome_t w);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    // Random item, mostly aimed at what the table currently holds.
    function automatic row_t random_item();
        row_t r;
        int pick;
        int occ_list[$];
        for (int s = 0; s < NSLOT; s++)
            if (shadow_occ[s]) occ_list = {occ_list, s};
        r = item(OP_PARK, {$urandom, $urandom}, 8'($urandom_range(0, 3)),
                 SW'($urandom_range(0, 127)));
        if ($urandom_range(0, 3) != 0) r.tag = tag_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 4) == 0) r.attr = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            r.op = OP_PARK;
        end else if (pick < 62) begin
            r.op = OP_LEAVE;
            if (occ_list.size() > 0 && $urandom_range(0, 9) < 7)
                r.idx = SW'(occ_list[$urandom_range(0, occ_list.size() - 1)] + 1);
        end else if (pick < 77) begin
            r.op = OP_FIND;
            if (occ_list.size() > 0 && $urandom_range(0, 9) < 7)
                r.tag = shadow_tag[occ_list[$urandom_range(0, occ_list.size() - 1)]];
        end else if (pick < 87) begin
            r.op = OP_LIST_SLOTS;
        end else if (pick < 97) begin
            r.op = OP_LIST_TAGS;
        end else begin
            r.op = OPW'($urandom_range(5, 7));
        end
        return r;
    endfunction

    // Offer one item and hold it until accepted; valid stays high on return.
    task automatic offer(row_t r);
        bit got;
        if (sender_idles && $urandom_range(0, 99) < 17) begin
            s_valid <= 1'b0;
            while ($urandom_range(0, 99) < 60) @(posedge aclk);
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= r.op;
        s_tag        <= r.tag;
        s_attribute  <= r.attr;
        s_slot_index <= r.idx;
        got = 1'b0;
        while (!got) begin
            @(negedge aclk);
            got = s_ready;
            @(posedge aclk);
        end
        // Accepted at this edge: predict now, before any result can show.
        table_step(r);
        if (r.typed)
            awaited_results = {awaited_results, r.want};
        else
            foreach (step_results[i]) awaited_results = {awaited_results, step_results[i]};
    endtask

    // Drop valid, wait for every result, then let the block settle.
    task automatic drain_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_slot_count(logic [SW-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        slot_limit = value;
    endtask

    task automatic check_field(string what, logic [TAGW-1:0] want, logic [TAGW-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random ready, one long hold-off, one steady stretch
    // ---------------------------------------------------------------
    initial begin
        outcome_t w;
        bit       held_off;
        m_ready = 1'b0;
        results_seen = 0;
        held_off = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && results_seen == 30 && !held_off) begin
                // hold off long enough for the block to back up its input
                held_off = 1'b1;
                m_ready <= 1'b0;
                for (int c = 0; c < 400; c++) @(posedge aclk);
            end
            if (results_seen >= 150 && results_seen < 260)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 99) >= 17);
            @(negedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, actual status %h slot %h",
                             $time, m_status, m_result_slot);
                end else begin
                    w = awaited_results.pop_front();
                    check_field("status", TAGW'(w.status), TAGW'(m_status));
                    check_field("result_slot", TAGW'(w.slot), TAGW'(m_result_slot));
                    check_field("result_tag", w.tag, m_result_tag);
                    check_field("result_attribute", TAGW'(w.attr), TAGW'(m_result_attribute));
                    check_field("last", TAGW'(w.last), TAGW'(m_last));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        logic [SW-1:0] phase_counts[6];
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_op         = OP_PARK;
        s_tag        = '0;
        s_attribute  = '0;
        s_slot_index = '0;
        errors       = 0;
        sender_idles = 1'b1;
        shadow_count = 0;
        slot_limit   = NSLOT;
        for (int s = 0; s < NSLOT; s++) begin
            shadow_occ[s]  = 1'b0;
            shadow_tag[s]  = '0;
            shadow_attr[s] = '0;
            shadow_rank[s] = 0;
        end
        tag_pool[0] = '1;
        tag_pool[1] = '0;
        tag_pool[2] = 64'h4142_4331_3233_3400;
        tag_pool[3] = {$urandom, $urandom};

        // Directed rows; obvious answers typed in, the rest predicted.
        add_row(typed_item(item(OP_LEAVE, '0, '0, '0),
                           mk(ST_EMPTY, '0, '0, '0, 1'b1)));
        add_row(typed_item(item(OP_FIND, '0, '0, '0),
                           mk(ST_NOT_FOUND, '0, '0, '0, 1'b1)));
        add_row(typed_item(item(OP_LIST_SLOTS, '0, '0, '0),
                           mk(ST_NOT_FOUND, '0, '0, '0, 1'b1)));
        add_row(typed_item(item(OP_LIST_TAGS, '1, '1, '1),
                           mk(ST_NOT_FOUND, '0, '0, '0, 1'b1)));
        add_row(typed_item(item(OP_PARK, '1, '1, '0),
                           mk(ST_OK, 7'd1, '0, '0, 1'b1)));
        add_row(typed_item(item(OP_PARK, '0, '0, '1),
                           mk(ST_OK, 7'd2, '0, '0, 1'b1)));
        // duplicate tag: the later park must win on find
        add_row(item(OP_PARK, '1, '0, '0));
        add_row(item(OP_FIND, '1, '0, '0));
        add_row(item(OP_LIST_SLOTS, '0, '0, '0));
        add_row(item(OP_LIST_TAGS, '0, '0, '0));
        add_row(item(OP_LIST_TAGS, '0, '1, '0));
        add_row(typed_item(item(OP_LEAVE, '0, '0, 7'd1),
                           mk(ST_OK, 7'd1, '1, '1, 1'b1)));
        add_row(typed_item(item(OP_LEAVE, '0, '0, 7'd1),
                           mk(ST_EMPTY, '0, '0, '0, 1'b1)));
        add_row(typed_item(item(OP_LEAVE, '0, '0, 7'd64),
                           mk(ST_EMPTY, '0, '0, '0, 1'b1)));
        add_row(typed_item(item(OP_LEAVE, '0, '0, 7'd127),
                           mk(ST_EMPTY, '0, '0, '0, 1'b1)));
        add_row(item(OP_SPARE_5, '1, '1, '1));
        add_row(item(OP_SPARE_7, '0, '0, '0));
        // refills slot 1, now youngest in parking order
        add_row(item(OP_PARK, 64'h4142_4331_3233_3400, '0, '0));
        add_row(item(OP_FIND, '1, '0, '0));
        add_row(item(OP_LIST_SLOTS, '0, '0, '0));
        add_row(item(OP_LEAVE, '0, '0, 7'd3));
        add_row(item(OP_FIND, '1, '0, '0));
        add_row(item(OP_LIST_TAGS, '0, '0, '0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) offer(dir_rows[i]);
        drain_idle();

        // Random phases; include above-range, smallest, zero and full settings.
        phase_counts[0] = 7'd127;
        phase_counts[1] = 7'd1;
        phase_counts[2] = 7'd0;
        phase_counts[3] = 7'd5;
        phase_counts[4] = 7'd64;
        phase_counts[5] = SW'($urandom_range(1, 64));
        for (int p = 0; p < 6; p++) begin
            write_slot_count(phase_counts[p]);
            sender_idles = (p != 4);  // one phase with no gaps on the input
            for (int k = 0; k < 18; k++) offer(random_item());
            drain_idle();
        end

        if (errors == 0 && awaited_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(12 * 900000);
        $display("tb_top: errors");
        $finish;
    end

endmodule
